### hw/rtl/nec_ir_frame_decoder_assert.svh
// ----------------------------------------------------------------------------
// NEC IR decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef NEC_IR_FRAME_DECODER_ASSERT_SVH
`define NEC_IR_FRAME_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NEC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NEC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/nec_ir_pkg.sv
// ----------------------------------------------------------------------------
// NEC IR decoder package
// Event codes, threshold register indexes and their reset values.
// ----------------------------------------------------------------------------
package nec_ir_pkg;

    localparam int CMD_W   = 3;
    localparam int WIDTH_W = 16;
    localparam int NUM_REGS = 8;
    localparam int REG_IDX_W = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_RISE  = 3'd0,
        CMD_FALL  = 3'd1,
        CMD_TICK  = 3'd2,
        CMD_SCAN  = 3'd3,
        CMD_CLEAR = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        REG_ZERO_MIN   = 3'd0,
        REG_ZERO_MAX   = 3'd1,
        REG_ONE_MIN    = 3'd2,
        REG_ONE_MAX    = 3'd3,
        REG_REPEAT_MIN = 3'd4,
        REG_REPEAT_MAX = 3'd5,
        REG_LEADER_MIN = 3'd6,
        REG_LEADER_MAX = 3'd7
    } reg_idx_t;

    typedef logic [WIDTH_W-1:0] width_t;

    localparam width_t REG_RESET [NUM_REGS] = '{
        16'd300, 16'd800, 16'd1400, 16'd1800,
        16'd2200, 16'd2600, 16'd4200, 16'd4700
    };

endpackage

### hw/rtl/nec_ir_frame_decoder.sv
// ----------------------------------------------------------------------------
// NEC infrared frame decoder
// Turns edge, tick, scan and clear events into key codes and frame status.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one event per transaction:
//   command selects rising edge, falling edge (with pulse_width in us),
//   10 ms timeout tick, scan or clear. Every event yields exactly one result
//   transaction on the output channel (out_valid / out_stall) with key_code,
//   key_valid, address_byte, repeat_count and frame_active.
//   The configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data)
//   writes the eight width window bounds; cfg_ready is always high, and
//   indexes beyond seven are dropped. Write it only while the block is idle.
// Timing:
//   An event passes the input register, then the decode logic into the result
//   register. Throughput is one event per cycle while the receiver does not
//   stall; the decode state updates in the same cycle that the event leaves
//   the input register.
// Reset:
//   rst_n clears all frame state, empties both stages and restores the
//   default windows. When the receiver stalls, the result register holds,
//   then the input register fills and in_stall rises.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder #(
    parameter int IDLE_LIMIT = 14
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // event input
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [nec_ir_pkg::CMD_W-1:0]        command,
    input  logic [nec_ir_pkg::WIDTH_W-1:0]      pulse_width,
    // result output
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [7:0]                          key_code,
    output logic                                key_valid,
    output logic [7:0]                          address_byte,
    output logic [7:0]                          repeat_count,
    output logic                                frame_active,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nec_ir_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [nec_ir_pkg::WIDTH_W-1:0]      cfg_data
);

    localparam int IDLE_W = $clog2(IDLE_LIMIT + 1);
    localparam logic [IDLE_W-1:0] IDLE_MAX = IDLE_W'(IDLE_LIMIT);

    // Threshold registers
    nec_ir_pkg::width_t cfg_reg [nec_ir_pkg::NUM_REGS];

    // Input stage
    logic                                   s1_valid_reg;
    logic [nec_ir_pkg::CMD_W-1:0]           s1_cmd_reg;
    nec_ir_pkg::width_t                     s1_width_reg;

    // Decoder state
    logic               receiving_reg,   receiving_next;
    logic               frame_ready_reg, frame_ready_next;
    logic               high_seen_reg,   high_seen_next;
    logic [IDLE_W-1:0]  idle_ticks_reg,  idle_ticks_next;
    logic [31:0]        bit_shift_reg,   bit_shift_next;
    logic [7:0]         repeats_reg,     repeats_next;
    logic [7:0]         last_addr_reg,   last_addr_next;
    logic [7:0]         code_next;

    // Result stage
    logic               out_valid_reg;
    logic [7:0]         key_code_reg;
    logic               key_valid_reg;
    logic [7:0]         address_reg;
    logic [7:0]         repeat_cnt_reg;
    logic               active_reg;

    logic               out_advance;
    logic               s1_fire;
    logic               in_fire;
    logic               win_zero, win_one, win_repeat, win_leader;
    logic [7:0]         addr_b, naddr_b, cmd_b, ncmd_b;

    assign cfg_ready   = 1'b1;
    assign out_advance = !out_valid_reg || !out_stall;
    assign s1_fire     = s1_valid_reg && out_advance;
    assign in_stall    = s1_valid_reg && !out_advance;
    assign in_fire     = in_valid && !in_stall;

    // Configuration writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < nec_ir_pkg::NUM_REGS; i++)
            begin
                cfg_reg[i] <= nec_ir_pkg::REG_RESET[i];
            end
        end
        else if (cfg_valid && cfg_ready && !cfg_index[nec_ir_pkg::REG_IDX_W-1])
        begin
            cfg_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    // Input register: load whenever it is empty or draining this cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_cmd_reg   <= command;
            s1_width_reg <= pulse_width;
        end
    end

    // Width windows; both bounds of each window are exclusive
    assign win_zero   = (s1_width_reg > cfg_reg[nec_ir_pkg::REG_ZERO_MIN])
                     && (s1_width_reg < cfg_reg[nec_ir_pkg::REG_ZERO_MAX]);
    assign win_one    = (s1_width_reg > cfg_reg[nec_ir_pkg::REG_ONE_MIN])
                     && (s1_width_reg < cfg_reg[nec_ir_pkg::REG_ONE_MAX]);
    assign win_repeat = (s1_width_reg > cfg_reg[nec_ir_pkg::REG_REPEAT_MIN])
                     && (s1_width_reg < cfg_reg[nec_ir_pkg::REG_REPEAT_MAX]);
    assign win_leader = (s1_width_reg > cfg_reg[nec_ir_pkg::REG_LEADER_MIN])
                     && (s1_width_reg < cfg_reg[nec_ir_pkg::REG_LEADER_MAX]);

    assign addr_b  = bit_shift_reg[31:24];
    assign naddr_b = bit_shift_reg[23:16];
    assign cmd_b   = bit_shift_reg[15:8];
    assign ncmd_b  = bit_shift_reg[7:0];

    // Event decode
    always_comb
    begin
        receiving_next   = receiving_reg;
        frame_ready_next = frame_ready_reg;
        high_seen_next   = high_seen_reg;
        idle_ticks_next  = idle_ticks_reg;
        bit_shift_next   = bit_shift_reg;
        repeats_next     = repeats_reg;
        last_addr_next   = last_addr_reg;
        code_next        = 8'd0;

        unique case (s1_cmd_reg)
            nec_ir_pkg::CMD_RISE:
            begin
                high_seen_next = 1'b1;
            end
            nec_ir_pkg::CMD_FALL:
            begin
                if (high_seen_reg)
                begin
                    if (receiving_reg)
                    begin
                        if (win_zero)
                        begin
                            bit_shift_next = {bit_shift_reg[30:0], 1'b0};
                        end
                        else if (win_one)
                        begin
                            bit_shift_next = {bit_shift_reg[30:0], 1'b1};
                        end
                        else if (win_repeat)
                        begin
                            repeats_next    = repeats_reg + 8'd1;
                            idle_ticks_next = '0;
                        end
                    end
                    else if (win_leader)
                    begin
                        receiving_next = 1'b1;
                        repeats_next   = 8'd0;
                    end
                end
                high_seen_next = 1'b0;
            end
            nec_ir_pkg::CMD_TICK:
            begin
                if (receiving_reg)
                begin
                    high_seen_next = 1'b0;
                    if (idle_ticks_reg == '0)
                    begin
                        frame_ready_next = 1'b1;
                    end
                    if (idle_ticks_reg < IDLE_MAX)
                    begin
                        idle_ticks_next = idle_ticks_reg + IDLE_W'(1);
                    end
                    else
                    begin
                        receiving_next  = 1'b0;
                        idle_ticks_next = '0;
                    end
                end
            end
            nec_ir_pkg::CMD_SCAN:
            begin
                if (frame_ready_reg)
                begin
                    last_addr_next = addr_b;
                    if ((addr_b == ~naddr_b) && (cmd_b == ~ncmd_b))
                    begin
                        code_next = cmd_b;
                    end
                    // drop the frame on a failed check, a zero key code, or once it has closed
                    if ((code_next == 8'd0) || !receiving_reg)
                    begin
                        frame_ready_next = 1'b0;
                        repeats_next     = 8'd0;
                    end
                end
            end
            nec_ir_pkg::CMD_CLEAR:
            begin
                receiving_next   = 1'b0;
                frame_ready_next = 1'b0;
                high_seen_next   = 1'b0;
                idle_ticks_next  = '0;
                bit_shift_next   = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg   <= 1'b0;
            frame_ready_reg <= 1'b0;
            high_seen_reg   <= 1'b0;
            idle_ticks_reg  <= '0;
            bit_shift_reg   <= '0;
            repeats_reg     <= '0;
            last_addr_reg   <= '0;
        end
        else if (s1_fire)
        begin
            receiving_reg   <= receiving_next;
            frame_ready_reg <= frame_ready_next;
            high_seen_reg   <= high_seen_next;
            idle_ticks_reg  <= idle_ticks_next;
            bit_shift_reg   <= bit_shift_next;
            repeats_reg     <= repeats_next;
            last_addr_reg   <= last_addr_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            key_code_reg   <= code_next;
            key_valid_reg  <= (code_next != 8'd0);
            address_reg    <= last_addr_next;
            repeat_cnt_reg <= repeats_next;
            active_reg     <= receiving_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign key_code     = key_code_reg;
    assign key_valid    = key_valid_reg;
    assign address_byte = address_reg;
    assign repeat_count = repeat_cnt_reg;
    assign frame_active = active_reg;

endmodule

### hw/rtl/nec_ir_checker.sv
// ----------------------------------------------------------------------------
// NEC IR decoder port checker
// Port-level properties of the decoder, bound to every instance.
// ----------------------------------------------------------------------------
`include "nec_ir_frame_decoder_assert.svh"

module nec_ir_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_stall,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [7:0]                          key_code,
    input  logic                                key_valid,
    input  logic [7:0]                          address_byte,
    input  logic [7:0]                          repeat_count,
    input  logic                                frame_active,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready
);

    // all result fields side by side, for the hold check
    logic [25:0] result_bits;

    assign result_bits = {key_code, key_valid, address_byte, repeat_count, frame_active};

    `NEC_ASSERT_SAME(a_key_flag, out_valid, key_valid == (key_code != 8'd0), "key_valid mismatch")

    `NEC_ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall, "stall without back pressure")

    `NEC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result_bits), "stalled result changed")

    `NEC_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready, "config write refused")

endmodule

bind nec_ir_frame_decoder nec_ir_checker u_nec_ir_checker (.*);

### bench/tb_nec_ir_frame_decoder.sv
// ----------------------------------------------------------------------------
// NEC IR frame decoder testbench
// Streams edge, tick, scan and clear events through the decoder under random
// throttling on both channels and several width window settings. Each result
// is checked field by field against a behavioral decoder kept in this bench.
// ----------------------------------------------------------------------------
module tb_nec_ir_frame_decoder;

    import nec_ir_pkg::*;

    localparam int IDLE_LIMIT     = 14;
    localparam int RESET_CYCLES   = 8;
    localparam int LONG_HOLD      = 64;    // cycles of output back-pressure
    localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transaction
    localparam int MAX_SHOWN      = 10;    // mismatches printed in full
    localparam int SETTLE_CYCLES  = 8;     // quiet time after the last result

    // command codes the decoder must ignore
    localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;

    // width window settings, in register order
    localparam width_t SET_SHIFTED [NUM_REGS] = '{
        16'd100, 16'd400, 16'd900, 16'd1300, 16'd2000, 16'd3000, 16'd8000, 16'd9500
    };
    // overlapping windows: zero wins over one, one over repeat
    localparam width_t SET_OVERLAP [NUM_REGS] = '{
        16'd100, 16'd2000, 16'd500, 16'd3000, 16'd1000, 16'd4000, 16'd200, 16'd5000
    };
    localparam width_t SET_WIDE_OPEN [NUM_REGS] = '{
        16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF
    };
    localparam width_t SET_SHUT [NUM_REGS] = '{
        16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0
    };
    // single-value windows
    localparam width_t SET_NARROW [NUM_REGS] = '{
        16'd499, 16'd501, 16'd1599, 16'd1601, 16'd2399, 16'd2401, 16'd4499, 16'd4501
    };

    typedef enum logic [1:0] {
        IDLE_RX_HEAVY,  // sender idles 25 %, receiver 81 %
        IDLE_TX_HEAVY,  // sender idles 81 %, receiver 25 %
        IDLE_NONE
    } idle_mode_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        width_t           width;
    } ir_event_t;

    typedef struct packed {
        logic [7:0] key_code;
        logic       key_valid;
        logic [7:0] address_byte;
        logic [7:0] repeat_count;
        logic       frame_active;
    } ir_report_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic [CMD_W-1:0]     command     = CMD_RISE;
    width_t               pulse_width = '0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    logic [7:0]           key_code;
    logic                 key_valid;
    logic [7:0]           address_byte;
    logic [7:0]           repeat_count;
    logic                 frame_active;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [REG_IDX_W-1:0] cfg_index   = '0;
    width_t               cfg_data    = '0;

    nec_ir_frame_decoder #(
        .IDLE_LIMIT  (IDLE_LIMIT)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .pulse_width  (pulse_width),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .key_code     (key_code),
        .key_valid    (key_valid),
        .address_byte (address_byte),
        .repeat_count (repeat_count),
        .frame_active (frame_active),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    ir_event_t  event_backlog [$];   // events waiting to be sent, front is on the bus
    ir_report_t decoded_reports [$]; // predicted results, oldest first
    idle_mode_t idle_mode = IDLE_RX_HEAVY;

    int queued_events   = 0;  // events that the decoder acts on
    int events_accepted = 0;
    int reports_seen    = 0;
    int keys_decoded    = 0;
    int frames_closed   = 0;
    int fail_count      = 0;
    int hold_left       = 0;
    int quiet_cycles    = 0;
    ir_event_t sent_event;

    // Decoder model: its own copy of the window bounds and frame state
    width_t     bound [NUM_REGS];
    logic       rx_open     = 1'b0;
    logic       ready_flag  = 1'b0;
    logic       pulse_armed = 1'b0;
    logic [3:0] idle_cnt    = '0;
    logic [31:0] shift_reg  = '0;
    logic [7:0] repeat_cnt  = '0;
    logic [7:0] addr_seen   = '0;

    function automatic int tx_idle_pct();
        case (idle_mode)
            IDLE_RX_HEAVY: return 25;
            IDLE_TX_HEAVY: return 81;
            default:       return 0;
        endcase
    endfunction

    function automatic int rx_stall_pct();
        case (idle_mode)
            IDLE_RX_HEAVY: return 81;
            IDLE_TX_HEAVY: return 25;
            default:       return 0;
        endcase
    endfunction

    function automatic logic width_in(width_t w, width_t lo, width_t hi);
        return (w > lo) && (w < hi);
    endfunction

    // Apply one event to the model state and return the result it reports.
    function automatic ir_report_t decode_ir_event(ir_event_t ev);
        ir_report_t rpt;
        rpt = '0;
        case (ev.cmd)
            CMD_RISE:
                pulse_armed = 1'b1;
            CMD_FALL:
            begin
                if (pulse_armed)
                begin
                    if (rx_open)
                    begin
                        // windows are tried in the order zero, one, repeat
                        if (width_in(ev.width, bound[REG_ZERO_MIN], bound[REG_ZERO_MAX]))
                            shift_reg = {shift_reg[30:0], 1'b0};
                        else if (width_in(ev.width, bound[REG_ONE_MIN], bound[REG_ONE_MAX]))
                            shift_reg = {shift_reg[30:0], 1'b1};
                        else if (width_in(ev.width, bound[REG_REPEAT_MIN],
                                          bound[REG_REPEAT_MAX]))
                        begin
                            repeat_cnt = repeat_cnt + 8'd1;
                            idle_cnt   = '0;
                        end
                    end
                    else if (width_in(ev.width, bound[REG_LEADER_MIN], bound[REG_LEADER_MAX]))
                    begin
                        rx_open    = 1'b1;
                        repeat_cnt = '0;
                    end
                end
                pulse_armed = 1'b0;
            end
            CMD_TICK:
            begin
                if (rx_open)
                begin
                    pulse_armed = 1'b0;
                    if (idle_cnt == 0)
                        ready_flag = 1'b1;
                    if (idle_cnt < IDLE_LIMIT)
                        idle_cnt = idle_cnt + 4'd1;
                    else
                    begin
                        rx_open  = 1'b0;
                        idle_cnt = '0;
                        frames_closed++;
                    end
                end
            end
            CMD_SCAN:
            begin
                if (ready_flag)
                begin
                    addr_seen = shift_reg[31:24];
                    if (shift_reg[31:24] == ~shift_reg[23:16] &&
                        shift_reg[15:8] == ~shift_reg[7:0])
                        rpt.key_code = shift_reg[15:8];
                    if (rpt.key_code == 0 || !rx_open)
                    begin
                        ready_flag = 1'b0;
                        repeat_cnt = '0;
                    end
                end
            end
            CMD_CLEAR:
            begin
                rx_open     = 1'b0;
                ready_flag  = 1'b0;
                pulse_armed = 1'b0;
                idle_cnt    = '0;
                shift_reg   = '0;
            end
            default: ;
        endcase
        rpt.key_valid    = (rpt.key_code != 0);
        rpt.address_byte = addr_seen;
        rpt.repeat_count = repeat_cnt;
        rpt.frame_active = rx_open;
        if (rpt.key_valid)
            keys_decoded++;
        return rpt;
    endfunction

    // ------------------------------------------------------------------------
    // Event driver: send the backlog front, hold it while stalled, idle at
    // random between transactions.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            command     <= CMD_RISE;
            pulse_width <= '0;
        end
        else
        begin
            // a transaction completed: predict its result and drop it
            if (in_valid && !in_stall)
            begin
                sent_event = event_backlog.pop_front();
                decoded_reports.push_back(decode_ir_event(sent_event));
                events_accepted++;
            end
            if (in_valid && in_stall)
                ;  // hold the stalled payload
            else if (event_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct())
            begin
                in_valid    <= 1'b1;
                command     <= event_backlog[0].cmd;
                pulse_width <= event_backlog[0].width;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: compare each result transaction with the oldest
    // prediction, then pick the stall for the next cycle.
    // ------------------------------------------------------------------------
    task automatic check_report();
        ir_report_t want;
        ir_report_t got;
        got.key_code     = key_code;
        got.key_valid    = key_valid;
        got.address_byte = address_byte;
        got.repeat_count = repeat_count;
        got.frame_active = frame_active;
        reports_seen++;
        // every 400 results, hold off long enough for the decoder to back up
        if (reports_seen % 400 == 200)
            hold_left = LONG_HOLD;
        if (decoded_reports.size() == 0)
        begin
            fail_count++;
            if (fail_count <= MAX_SHOWN)
                $display("result %0d arrived with no event pending: key %02h addr %02h",
                         reports_seen, got.key_code, got.address_byte);
            return;
        end
        want = decoded_reports.pop_front();
        if (got.key_code !== want.key_code || got.key_valid !== want.key_valid ||
            got.address_byte !== want.address_byte ||
            got.repeat_count !== want.repeat_count ||
            got.frame_active !== want.frame_active)
        begin
            fail_count++;
            if (fail_count <= MAX_SHOWN)
            begin
                $display("result %0d mismatch (exp/got): key %02h/%02h valid %0b/%0b",
                         reports_seen, want.key_code, got.key_code,
                         want.key_valid, got.key_valid);
                $display("    addr %02h/%02h repeats %0d/%0d active %0b/%0b",
                         want.address_byte, got.address_byte,
                         want.repeat_count, got.repeat_count,
                         want.frame_active, got.frame_active);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
                check_report();
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < rx_stall_pct());
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no transaction moves for too long
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles < WATCHDOG_LIMIT)
            quiet_cycles <= quiet_cycles + 1;
        else
        begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("nec_ir_frame_decoder verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------
    task automatic add_event(input logic [CMD_W-1:0] cmd, input width_t w);
        ir_event_t ev;
        ev.cmd   = cmd;
        ev.width = w;
        event_backlog.push_back(ev);
        if (cmd <= CMD_CLEAR)
            queued_events++;
    endtask

    // rising edge with a random unused width, then the falling edge
    task automatic add_pulse(input width_t w);
        add_event(CMD_RISE, width_t'($urandom));
        add_event(CMD_FALL, w);
    endtask

    // Width strictly inside (lo, hi); now and then a bound itself, which must
    // miss the window. An empty window gives any width.
    function automatic width_t window_width(width_t lo, width_t hi);
        if ($urandom_range(19) == 0)
            return $urandom_range(1) ? lo : hi;
        if (int'(hi) > int'(lo) + 1)
            return width_t'($urandom_range(int'(hi) - 1, int'(lo) + 1));
        return width_t'($urandom);
    endfunction

    task automatic add_noise(input int count);
        repeat (count)
        begin
            case ($urandom_range(9))
                0:       add_event(CMD_W'($urandom_range(CMD_RSVD_LAST, CMD_RSVD_FIRST)),
                                   width_t'($urandom));
                1, 2:    add_event(CMD_FALL, width_t'($urandom));
                3, 4:    add_pulse(width_t'($urandom));
                default: add_event(CMD_W'($urandom_range(CMD_CLEAR)), width_t'($urandom));
            endcase
        end
    endtask

    // One frame: leader, address and command bytes with their complements
    // (sometimes broken, cut short or run long), scans, repeat codes and timeout ticks.
    task automatic add_frame(input int repeat_pulses);
        logic [7:0]  addr;
        logic [7:0]  code;
        logic [31:0] word;
        int          nbits;
        addr = 8'($urandom);
        code = ($urandom_range(4) == 0) ? 8'd0 : 8'($urandom);
        word = {addr, ~addr, code, ~code};
        if ($urandom_range(3) == 0)
            word[$urandom_range(31)] ^= 1'b1;
        if ($urandom_range(4) == 0)
            add_event(CMD_CLEAR, width_t'($urandom));
        add_pulse(window_width(bound[REG_LEADER_MIN], bound[REG_LEADER_MAX]));
        nbits = ($urandom_range(5) == 0) ? $urandom_range(40) : 32;
        for (int k = nbits - 1; k >= 0; k--)
        begin
            if ($urandom_range(29) == 0)
                add_noise(1);
            if (word[k % 32])
                add_pulse(window_width(bound[REG_ONE_MIN], bound[REG_ONE_MAX]));
            else
                add_pulse(window_width(bound[REG_ZERO_MIN], bound[REG_ZERO_MAX]));
        end
        add_event(CMD_TICK, width_t'($urandom));
        add_event(CMD_SCAN, width_t'($urandom));
        for (int k = 0; k < repeat_pulses; k++)
        begin
            add_pulse(window_width(bound[REG_REPEAT_MIN], bound[REG_REPEAT_MAX]));
            if ($urandom_range(3) == 0)
                add_event(CMD_TICK, width_t'($urandom));
            if ($urandom_range(3) == 0)
                add_event(CMD_SCAN, width_t'($urandom));
        end
        // enough ticks now and then to age the frame out
        repeat ($urandom_range(20))
            add_event(CMD_TICK, width_t'($urandom));
        add_event(CMD_SCAN, width_t'($urandom));
    endtask

    task automatic fill_random(input int count);
        int target;
        target = queued_events + count;
        while (queued_events < target)
        begin
            if ($urandom_range(4) != 0)
                add_frame($urandom_range(3));
            else
                add_noise($urandom_range(12, 1));
        end
    endtask

    // ------------------------------------------------------------------------
    // Configuration and phase control
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input width_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx < NUM_REGS)
            bound[idx[$clog2(NUM_REGS)-1:0]] = data;
    endtask

    task automatic program_windows(input width_t vals [NUM_REGS]);
        for (int i = 0; i < NUM_REGS; i++)
            write_reg(REG_IDX_W'(i), vals[i]);
        // a write past the last register must be dropped
        write_reg(REG_IDX_W'($urandom_range(2**REG_IDX_W - 1, NUM_REGS)),
                  width_t'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Wait until every event has been sent and every result has come back.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (event_backlog.size() != 0 || decoded_reports.size() != 0);
    endtask

    task automatic run_phase(input idle_mode_t mode, input width_t vals [NUM_REGS],
                             input int count);
        wait_drained();
        idle_mode <= mode;
        program_windows(vals);
        fill_random(count);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        foreach (bound[i])
            bound[i] = REG_RESET[i];
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed events against the reset windows
        add_event(CMD_FALL, '0);               // falling edge with no rising edge
        add_event(CMD_TICK, '1);               // tick with no frame open
        add_event(CMD_SCAN, '0);               // scan with nothing ready
        add_event(CMD_RSVD_FIRST, '1);         // unknown commands
        add_event(CMD_RSVD_LAST, 16'h5A5A);
        add_pulse(16'hFFFF);                   // outside every window, no frame
        add_pulse(16'd4500);                   // leader opens the frame
        add_pulse('0);                         // width in no window
        add_pulse(16'd800);                    // exactly on a bound: no bit
        add_pulse(16'd500);                    // zero bit
        add_pulse(16'd1600);                   // one bit
        add_pulse(16'd2400);                   // repeat code
        add_event(CMD_TICK, '0);               // first tick marks the frame ready
        add_event(CMD_SCAN, '1);               // check bytes fail
        add_event(CMD_CLEAR, '0);

        fill_random(120);
        run_phase(IDLE_RX_HEAVY, SET_SHIFTED, 100);
        run_phase(IDLE_TX_HEAVY, SET_OVERLAP, 80);
        run_phase(IDLE_TX_HEAVY, SET_WIDE_OPEN, 60);
        run_phase(IDLE_NONE, SET_SHUT, 40);
        run_phase(IDLE_NONE, SET_NARROW, 60);
        run_phase(IDLE_NONE, REG_RESET, 30);
        // enough repeat codes in one frame to wrap the repeat count
        add_frame(260);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        fail_count += decoded_reports.size();

        $display("covered %0d events and %0d results over seven window settings",
                 events_accepted, reports_seen);
        $display("%0d keys validated, %0d frames closed by timeout, %0d failures",
                 keys_decoded, frames_closed, fail_count);
        if (fail_count == 0)
            $display("nec_ir_frame_decoder verification clean");
        else
            $display("nec_ir_frame_decoder verification failed");
        $finish;
    end

endmodule

### nec_ir_frame_decoder.f
+incdir+hw/rtl
hw/rtl/nec_ir_pkg.sv
hw/rtl/nec_ir_frame_decoder.sv
hw/rtl/nec_ir_checker.sv
bench/tb_nec_ir_frame_decoder.sv
